@@ rtl/gbc_pkg.sv @@
// ----------------------------------------------------------------------------
// gbc_pkg
// Shared types and constants of the gyro bias calibration and correction block
// ----------------------------------------------------------------------------
package gbc_pkg;

  localparam int RAW_W     = 16;
  localparam int FIX_W     = 17;
  localparam int DPS_W     = 19;
  localparam int DPS_MAG_W = 18;

  // floor(m * 512 / 131) == (m * DPS_RECIP) >> DPS_SHIFT for m < 2^16
  localparam int                    DPS_RECIP_W = 27;
  localparam logic [DPS_RECIP_W-1:0] DPS_RECIP  = 27'd65572020;
  localparam int                    DPS_SHIFT   = 24;
  localparam int                    DPS_PROD_W  = RAW_W + DPS_RECIP_W;

  // bias = trunc0(floor(s * coef / 2^15) / 2^16)
  localparam int COEF_W     = 32;
  localparam int BIAS_FLOOR = 15;
  localparam int BIAS_SHIFT = 31;

  typedef enum logic [3:0] {
    PH_CAL  = 4'b0001,
    PH_MUL  = 4'b0010,
    PH_BIAS = 4'b0100,
    PH_RUN  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic signed [FIX_W-1:0] fixed;
    logic signed [DPS_W-1:0] dps;
  } axis_res_t;

endpackage

@@ rtl/gyro_bias_calibrate_correct.sv @@
// ----------------------------------------------------------------------------
// gyro_bias_calibrate_correct
// Sums the first WINDOW samples per axis, fixes a bias from that sum, then
// gives bias-corrected rates in raw LSB and in deg/s (Q.9) for every later sample
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------------
//  in      | in_valid / in_ready   | in_rate_x, in_rate_y, in_rate_z
//  out     | out_valid / out_ready | out_fixed_*, out_dps_*, out_offset_*
//
//  one request per cycle while the output is not stalled; a result passes the input register, then the output register
//  the first WINDOW requests give no result; after the last of them the bias
//  is formed by a multiply step, then a round step, holding one request in the
//  input register meanwhile
//  rst_n (synchronous) clears the sums, count, bias and all valid flags
//  a stalled output holds the input register, which then drops in_ready
// ----------------------------------------------------------------------------
module gyro_bias_calibrate_correct #(
  parameter int WINDOW = 512
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [gbc_pkg::RAW_W-1:0]    in_rate_x,
  input  logic signed [gbc_pkg::RAW_W-1:0]    in_rate_y,
  input  logic signed [gbc_pkg::RAW_W-1:0]    in_rate_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [gbc_pkg::FIX_W-1:0]    out_fixed_x,
  output logic signed [gbc_pkg::FIX_W-1:0]    out_fixed_y,
  output logic signed [gbc_pkg::FIX_W-1:0]    out_fixed_z,
  output logic signed [gbc_pkg::DPS_W-1:0]    out_dps_x,
  output logic signed [gbc_pkg::DPS_W-1:0]    out_dps_y,
  output logic signed [gbc_pkg::DPS_W-1:0]    out_dps_z,
  output logic signed [gbc_pkg::RAW_W-1:0]    out_offset_x,
  output logic signed [gbc_pkg::RAW_W-1:0]    out_offset_y,
  output logic signed [gbc_pkg::RAW_W-1:0]    out_offset_z
);

  localparam int CNT_W = $clog2(WINDOW);
  localparam int SUM_W = gbc_pkg::RAW_W + CNT_W;
  localparam int MUL_W = SUM_W + gbc_pkg::COEF_W;
  localparam logic [gbc_pkg::COEF_W-1:0] COEF = gbc_pkg::COEF_W'(32'h7FFFFFFF / WINDOW);
  localparam logic [CNT_W-1:0]           CNT_LAST = CNT_W'(WINDOW - 1);

  gbc_pkg::phase_t phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r;

  logic                             a_valid_r;
  logic signed [gbc_pkg::RAW_W-1:0] a_raw_r [3];
  logic                             a_fire;
  logic                             a_to_out;
  logic                             a_to_sum;

  logic signed [SUM_W-1:0]          sum_r  [3];
  logic signed [MUL_W-1:0]          prod_r [3];
  logic signed [gbc_pkg::RAW_W-1:0] bias_r [3];

  logic signed [gbc_pkg::RAW_W-1:0] in_raw [3];
  gbc_pkg::axis_res_t               res    [3];

  logic                             out_valid_r, out_valid_nxt;
  logic signed [gbc_pkg::FIX_W-1:0] out_fixed_r  [3];
  logic signed [gbc_pkg::DPS_W-1:0] out_dps_r    [3];
  logic signed [gbc_pkg::RAW_W-1:0] out_offset_r [3];

  assign in_raw[0] = in_rate_x;
  assign in_raw[1] = in_rate_y;
  assign in_raw[2] = in_rate_z;

  assign a_to_sum = a_valid_r && (phase_r == gbc_pkg::PH_CAL);
  assign a_to_out = a_valid_r && (phase_r == gbc_pkg::PH_RUN) && (!out_valid_r || out_ready);
  assign a_fire   = a_to_sum || a_to_out;
  assign in_ready = !a_valid_r || a_fire;

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      gbc_pkg::PH_CAL: begin
        if (a_to_sum && cnt_r == CNT_LAST) phase_nxt = gbc_pkg::PH_MUL;
      end
      gbc_pkg::PH_MUL:  phase_nxt = gbc_pkg::PH_BIAS;
      gbc_pkg::PH_BIAS: phase_nxt = gbc_pkg::PH_RUN;
      gbc_pkg::PH_RUN:  phase_nxt = gbc_pkg::PH_RUN;
      default:          phase_nxt = gbc_pkg::PH_CAL;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (a_to_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= gbc_pkg::PH_CAL;
      cnt_r       <= '0;
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sum_r[i]  <= '0;
        bias_r[i] <= '0;
      end
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_ready) a_valid_r <= in_valid;
      if (a_to_sum) begin
        cnt_r <= cnt_r + 1'b1;
        for (int i = 0; i < 3; i++) begin
          sum_r[i] <= sum_r[i] + SUM_W'(a_raw_r[i]);
        end
      end
      if (phase_r == gbc_pkg::PH_BIAS) begin
        for (int i = 0; i < 3; i++) begin
          // floor then truncate toward zero: bump negatives with a fraction
          bias_r[i] <= prod_r[i][gbc_pkg::BIAS_SHIFT +: gbc_pkg::RAW_W]
                     + gbc_pkg::RAW_W'(prod_r[i][MUL_W-1]
                       && (|prod_r[i][gbc_pkg::BIAS_SHIFT-1:gbc_pkg::BIAS_FLOOR]));
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready) begin
      for (int i = 0; i < 3; i++) a_raw_r[i] <= in_raw[i];
    end
    if (phase_r == gbc_pkg::PH_MUL) begin
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= MUL_W'(sum_r[i]) * $signed(MUL_W'(COEF));
      end
    end
    if (a_to_out) begin
      for (int i = 0; i < 3; i++) begin
        out_fixed_r[i]  <= res[i].fixed;
        out_dps_r[i]    <= res[i].dps;
        out_offset_r[i] <= bias_r[i];
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_axis
    gbc_axis_corr u_corr (
      .raw  (a_raw_r[g]),
      .bias (bias_r[g]),
      .res  (res[g])
    );
  end

  assign out_valid    = out_valid_r;
  assign out_fixed_x  = out_fixed_r[0];
  assign out_fixed_y  = out_fixed_r[1];
  assign out_fixed_z  = out_fixed_r[2];
  assign out_dps_x    = out_dps_r[0];
  assign out_dps_y    = out_dps_r[1];
  assign out_dps_z    = out_dps_r[2];
  assign out_offset_x = out_offset_r[0];
  assign out_offset_y = out_offset_r[1];
  assign out_offset_z = out_offset_r[2];

`ifndef SYNTHESIS
  a_out_only_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> phase_r == gbc_pkg::PH_RUN)
    else $error("result shown before the bias was formed");

  a_hold_while_bias: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == gbc_pkg::PH_MUL || phase_r == gbc_pkg::PH_BIAS) |-> !a_fire)
    else $error("request consumed while the bias is being formed");

  a_mul_then_bias: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == gbc_pkg::PH_MUL |=> phase_r == gbc_pkg::PH_BIAS)
    else $error("bias sequence skipped a step");

  a_bias_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == gbc_pkg::PH_RUN && $past(phase_r) == gbc_pkg::PH_RUN)
      |-> $stable(bias_r[0]) && $stable(sum_r[0]))
    else $error("bias or sum changed after calibration");
`endif

endmodule

@@ rtl/gbc_axis_corr.sv @@
// ----------------------------------------------------------------------------
// gbc_axis_corr
// Per-axis bias removal and conversion of the corrected rate to deg/s in Q.9
// ----------------------------------------------------------------------------
module gbc_axis_corr (
  input  logic signed [gbc_pkg::RAW_W-1:0] raw,
  input  logic signed [gbc_pkg::RAW_W-1:0] bias,
  output gbc_pkg::axis_res_t               res
);

  logic signed [gbc_pkg::FIX_W-1:0]      corr;
  logic        [gbc_pkg::FIX_W-1:0]      corr_neg;
  logic        [gbc_pkg::RAW_W-1:0]      mag;
  logic        [gbc_pkg::DPS_PROD_W-1:0] prod;
  logic        [gbc_pkg::DPS_MAG_W-1:0]  quo;
  logic        [gbc_pkg::DPS_W-1:0]      quo_ext;

  assign corr     = gbc_pkg::FIX_W'(raw) - gbc_pkg::FIX_W'(bias);
  assign corr_neg = -corr;
  // magnitude never exceeds 65535
  assign mag      = corr[gbc_pkg::FIX_W-1] ? corr_neg[gbc_pkg::RAW_W-1:0]
                                           : corr[gbc_pkg::RAW_W-1:0];
  assign prod     = gbc_pkg::DPS_PROD_W'(mag) * gbc_pkg::DPS_PROD_W'(gbc_pkg::DPS_RECIP);
  assign quo      = prod[gbc_pkg::DPS_SHIFT +: gbc_pkg::DPS_MAG_W];
  assign quo_ext  = gbc_pkg::DPS_W'(quo);

  // truncation toward zero: divide the magnitude, restore the sign
  assign res.fixed = corr;
  assign res.dps   = corr[gbc_pkg::FIX_W-1] ? -$signed(quo_ext) : $signed(quo_ext);

endmodule
